FILE: src/awts_pkg.sv
package awts_pkg;

   localparam int unsigned MaxTrianglesDefault = 1024;
   localparam int unsigned CoordW = 20;
   localparam int unsigned AreaW = 48;
   localparam int unsigned MinAreaW = 21;
   localparam int unsigned CountW = 11;
   localparam int unsigned IndexW = 10;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] CORNER_A = 2'd0;
   localparam logic [1:0] CORNER_B = 2'd1;
   localparam logic [1:0] CORNER_C = 2'd2;

   localparam logic [2:0] ST_SAMPLED = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_HELD = 3'd2;
   localparam logic [2:0] ST_ADDED = 3'd3;
   localparam logic [2:0] ST_DEGEN = 3'd4;
   localparam logic [2:0] ST_FULL = 3'd5;
   localparam logic [2:0] ST_CLEARED = 3'd6;

   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] corner;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic signed [19:0] pos_z;
      logic [31:0] rand_area;
      logic [15:0] rand_u;
      logic [15:0] rand_v;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic signed [19:0] out_x;
      logic signed [19:0] out_y;
      logic signed [19:0] out_z;
      logic [9:0] chosen_index;
      logic [10:0] triangle_count;
      logic [47:0] area_total;
   } rsp_word_type;

   typedef struct packed {
      logic signed [19:0] z;
      logic signed [19:0] y;
      logic signed [19:0] x;
   } point_type;

   // classified command from front to back
   typedef enum logic [2:0] {
      CMD_NOP = 3'd0,
      CMD_COMMIT = 3'd1,
      CMD_SAMPLE = 3'd2,
      CMD_CLEAR = 3'd3
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      point_type pa;
      point_type pb;
      point_type pc;
      logic [31:0] rand_area;
      logic [15:0] rand_u;
      logic [15:0] rand_v;
   } job_type;

endpackage

FILE: src/area_weighted_triangle_sampler.sv
// Channel   Direction  Handshake                 Word
// req_      in         req_valid / req_ready     awts_pkg::req_word_type
// rsp_      out        rsp_valid / rsp_ready     awts_pkg::rsp_word_type
// csr_      in         csr_write_enable          csr_write_data (min_area)
//
// The time of a commit is set by the 44-step square root; that of a sample,
// by the one-port table search. The back end takes one word at a time; the
// front queue holds two words, so the input keeps flowing while the back
// works, until the queue is full.
// Reset is synchronous; the table itself is not cleared, only its count and area total.
module area_weighted_triangle_sampler #(
   parameter int unsigned MAX_TRIANGLES = awts_pkg::MaxTrianglesDefault
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input awts_pkg::req_word_type req_word,
   output logic rsp_valid,
   input logic rsp_ready,
   output awts_pkg::rsp_word_type rsp_word,
   input logic csr_write_enable,
   input logic [20:0] csr_write_data
);

   logic [20:0] min_area_ff;
   logic job_valid, job_ready;
   awts_pkg::job_type job;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_area_ff <= '0;
      end else if (csr_write_enable) begin
         min_area_ff <= csr_write_data;
      end
   end

   // front: corner holding and op decode
   awts_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   // back: area, table, search, interpolation
   awts_back #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_back (
      .clock(clock), .reset(reset), .csr_min_area(min_area_ff),
      .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

endmodule

FILE: src/awts_front.sv
module awts_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input awts_pkg::req_word_type req_word,
   output logic job_valid,
   input logic job_ready,
   output awts_pkg::job_type job
);

   // pending corners a and b
   awts_pkg::point_type first_ff, first_in;
   awts_pkg::point_type second_ff, second_in;
   // two-entry queue
   awts_pkg::job_type q_ff [2];
   awts_pkg::job_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   awts_pkg::point_type cur;
   awts_pkg::job_type new_job;
   logic push, pop;

   assign cur = '{z: req_word.pos_z, y: req_word.pos_y, x: req_word.pos_x};
   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[0];
   assign pop = job_valid && job_ready;

   always_comb begin
      new_job.pa = first_ff;
      new_job.pb = second_ff;
      new_job.pc = cur;
      new_job.rand_area = req_word.rand_area;
      new_job.rand_u = req_word.rand_u;
      new_job.rand_v = req_word.rand_v;
      new_job.cmd = awts_pkg::CMD_NOP;
      first_in = first_ff;
      second_in = second_ff;
      case (req_word.operation)
         awts_pkg::OP_LOAD: begin
            case (req_word.corner)
               awts_pkg::CORNER_A: first_in = cur;
               awts_pkg::CORNER_B: second_in = cur;
               awts_pkg::CORNER_C: new_job.cmd = awts_pkg::CMD_COMMIT;
               default: new_job.cmd = awts_pkg::CMD_NOP;
            endcase
         end
         awts_pkg::OP_SAMPLE: new_job.cmd = awts_pkg::CMD_SAMPLE;
         awts_pkg::OP_CLEAR: new_job.cmd = awts_pkg::CMD_CLEAR;
         default: new_job.cmd = awts_pkg::CMD_NOP;
      endcase
      if (!push) begin
         first_in = first_ff;
         second_in = second_ff;
      end
   end

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) begin
            q_in[0] = new_job;
         end else begin
            q_in[1] = new_job;
         end
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         first_ff <= '0;
         second_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         first_ff <= first_in;
         second_ff <= second_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

endmodule

FILE: src/awts_back.sv
module awts_back #(
   parameter int unsigned MAX_TRIANGLES = awts_pkg::MaxTrianglesDefault
) (
   input logic clock,
   input logic reset,
   input logic [20:0] csr_min_area,
   input logic job_valid,
   output logic job_ready,
   input awts_pkg::job_type job,
   output logic rsp_valid,
   input logic rsp_ready,
   output awts_pkg::rsp_word_type rsp_word
);

   localparam int unsigned AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int unsigned NW = $clog2(MAX_TRIANGLES + 1);
   localparam logic [NW-1:0] MaxN = NW'(MAX_TRIANGLES);

   typedef enum logic [11:0] {
      S_IDLE = 12'b000000000001,
      S_EDGE = 12'b000000000010,
      S_CROSS = 12'b000000000100,
      S_SQ = 12'b000000001000,
      S_SQRT = 12'b000000010000,
      S_COMMIT = 12'b000000100000,
      S_TGT = 12'b000001000000,
      S_SRCH = 12'b000010000000,
      S_SRCHW = 12'b000100000000,
      S_FETCH = 12'b001000000000,
      S_INTERP = 12'b010000000000,
      S_OUT = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   // table memories, one write and one read port each
   logic [59:0] mem_a [MAX_TRIANGLES];
   logic [59:0] mem_b [MAX_TRIANGLES];
   logic [59:0] mem_c [MAX_TRIANGLES];
   logic [47:0] mem_cum [MAX_TRIANGLES];
   logic [59:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic [47:0] rd_cum_ff;
   logic [AW-1:0] rd_addr;
   logic wr_en;

   logic [NW-1:0] count_ff, count_in;
   logic [47:0] total_ff, total_in;
   awts_pkg::job_type job_ff, job_in;

   // area datapath
   logic signed [20:0] e1_ff [3], e2_ff [3];
   logic signed [20:0] e1_in [3], e2_in [3];
   logic signed [42:0] cr_ff [3], cr_in [3];
   logic [86:0] ssum_ff, ssum_in;
   logic [87:0] ssum_x;
   logic [42:0] sq_mag;
   logic [20:0] sq_hi, sq_lo;
   logic [86:0] sq_val;
   logic [45:0] root_ff, root_in;
   logic [86:0] rem_ff, rem_in;
   logic [5:0] it_ff, it_in;
   logic [47:0] area;

   // search
   logic [NW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [NW-1:0] mid;
   logic [47:0] target_ff, target_in;
   logic [23:0] tot_half;
   logic [55:0] prod_part;
   logic [55:0] part_ff, part_in;
   logic [79:0] prod;

   // interpolation
   logic [16:0] u_ff, u_in, v_ff, v_in;
   logic signed [19:0] qpt [3];
   awts_pkg::rsp_word_type out_ff, out_in;
   logic rspv_ff, rspv_in;

   logic [88:0] trial;
   logic [86:0] rem_sh;
   logic signed [20:0] pa_c [3], pb_c [3], pc_c [3];
   logic signed [38:0] s_val [3];
   logic signed [38:0] s_rnd [3];

   assign job_ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_word = out_ff;
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign area = {3'b000, root_ff[45:1]};

   // target product in two 32x24 halves: low half first, then high half
   always_comb begin
      tot_half = it_ff[0] ? total_ff[47:24] : total_ff[23:0];
      prod_part = 56'(job_ff.rand_area) * 56'(tot_half);
      prod = {prod_part, 24'd0} + 80'(part_ff);
   end

   // square of one cross term from 21-bit halves
   always_comb begin
      sq_mag = cr_ff[it_ff[1:0]][42] ? 43'(-cr_ff[it_ff[1:0]]) : 43'(cr_ff[it_ff[1:0]]);
      sq_hi = sq_mag[41:21];
      sq_lo = sq_mag[20:0];
      sq_val = {3'b000, 42'(sq_hi * sq_hi), 42'd0} + 87'({42'(sq_hi * sq_lo), 22'd0})
         + 87'(sq_lo * sq_lo);
   end

   always_comb begin
      pa_c[0] = 21'(signed'(rd_a_ff[19:0]));
      pa_c[1] = 21'(signed'(rd_a_ff[39:20]));
      pa_c[2] = 21'(signed'(rd_a_ff[59:40]));
      pb_c[0] = 21'(signed'(rd_b_ff[19:0]));
      pb_c[1] = 21'(signed'(rd_b_ff[39:20]));
      pb_c[2] = 21'(signed'(rd_b_ff[59:40]));
      pc_c[0] = 21'(signed'(rd_c_ff[19:0]));
      pc_c[1] = 21'(signed'(rd_c_ff[39:20]));
      pc_c[2] = 21'(signed'(rd_c_ff[59:40]));
      for (int i = 0; i < 3; i++) begin
         s_val[i] = 39'(pb_c[i] - pa_c[i]) * 39'(signed'({1'b0, u_ff}))
            + 39'(pc_c[i] - pa_c[i]) * 39'(signed'({1'b0, v_ff}));
         s_rnd[i] = s_val[i] + 39'sd32768;
         qpt[i] = 20'(pa_c[i] + 21'(s_rnd[i] >>> 16));
      end
   end

   // restoring square root, one result bit per cycle over 44 bit pairs
   always_comb begin
      ssum_x = {1'b0, ssum_ff};
      rem_sh = {rem_ff[84:0], 2'b00} | 87'(ssum_x[87 - 2*it_ff -: 2]);
      trial = {2'b00, rem_sh} - {41'd0, root_ff, 2'b01};
   end

   always_comb begin
      rd_addr = mid[AW-1:0];
      if (state_ff == S_FETCH) rd_addr = lo_ff[AW-1:0];
   end

   assign wr_en = (state_ff == S_COMMIT) && (area > 48'(csr_min_area))
      && (count_ff < MaxN) && !(area > (48'hFFFFFFFFFFFF - total_ff));

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      count_in = count_ff;
      total_in = total_ff;
      e1_in = e1_ff;
      e2_in = e2_ff;
      cr_in = cr_ff;
      ssum_in = ssum_ff;
      root_in = root_ff;
      rem_in = rem_ff;
      it_in = it_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      target_in = target_ff;
      part_in = part_ff;
      u_in = u_ff;
      v_in = v_ff;
      out_in = out_ff;
      rspv_in = rspv_ff;
      if (rspv_ff && rsp_ready) rspv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid && job_ready) begin
               job_in = job;
               out_in = '0;
               it_in = '0;
               case (job.cmd)
                  awts_pkg::CMD_COMMIT: state_in = S_EDGE;
                  awts_pkg::CMD_SAMPLE: begin
                     if (count_ff == '0) begin
                        out_in.status = awts_pkg::ST_EMPTY;
                        state_in = S_OUT;
                     end else begin
                        state_in = S_TGT;
                     end
                  end
                  awts_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                     out_in.status = awts_pkg::ST_CLEARED;
                     state_in = S_OUT;
                  end
                  default: begin
                     out_in.status = awts_pkg::ST_HELD;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_EDGE: begin
            e1_in[0] = 21'(job_ff.pb.x) - 21'(job_ff.pa.x);
            e1_in[1] = 21'(job_ff.pb.y) - 21'(job_ff.pa.y);
            e1_in[2] = 21'(job_ff.pb.z) - 21'(job_ff.pa.z);
            e2_in[0] = 21'(job_ff.pc.x) - 21'(job_ff.pa.x);
            e2_in[1] = 21'(job_ff.pc.y) - 21'(job_ff.pa.y);
            e2_in[2] = 21'(job_ff.pc.z) - 21'(job_ff.pa.z);
            state_in = S_CROSS;
         end
         S_CROSS: begin
            cr_in[0] = 43'(e1_ff[1] * e2_ff[2]) - 43'(e1_ff[2] * e2_ff[1]);
            cr_in[1] = 43'(e1_ff[2] * e2_ff[0]) - 43'(e1_ff[0] * e2_ff[2]);
            cr_in[2] = 43'(e1_ff[0] * e2_ff[1]) - 43'(e1_ff[1] * e2_ff[0]);
            ssum_in = '0;
            it_in = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            // one square per cycle
            ssum_in = ssum_ff + sq_val;
            it_in = it_ff + 6'd1;
            if (it_ff == 6'd2) begin
               it_in = '0;
               root_in = '0;
               rem_in = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (!trial[88]) begin
               rem_in = trial[86:0];
               root_in = {root_ff[44:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               root_in = {root_ff[44:0], 1'b0};
            end
            it_in = it_ff + 6'd1;
            if (it_ff == 6'd43) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (area <= 48'(csr_min_area)) begin
               out_in.status = awts_pkg::ST_DEGEN;
            end else if (!wr_en) begin
               out_in.status = awts_pkg::ST_FULL;
            end else begin
               total_in = total_ff + area;
               count_in = count_ff + NW'(1);
               out_in.status = awts_pkg::ST_ADDED;
            end
            state_in = S_OUT;
         end
         S_TGT: begin
            if (it_ff == 6'd0) begin
               part_in = prod_part;
               it_in = 6'd1;
            end else begin
               target_in = prod[79:32];
               lo_in = '0;
               hi_in = count_ff;
               it_in = '0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               state_in = S_SRCHW;
            end else begin
               if (lo_ff >= count_ff) lo_in = count_ff - NW'(1);
               state_in = S_FETCH;
            end
         end
         S_SRCHW: begin
            if (rd_cum_ff < target_ff) lo_in = mid + NW'(1);
            else hi_in = mid;
            state_in = S_SRCH;
         end
         S_FETCH: begin
            u_in = {1'b0, job_ff.rand_u};
            v_in = {1'b0, job_ff.rand_v};
            if (({1'b0, job_ff.rand_u} + {1'b0, job_ff.rand_v}) > 17'd65536) begin
               u_in = 17'd65536 - {1'b0, job_ff.rand_u};
               v_in = 17'd65536 - {1'b0, job_ff.rand_v};
            end
            state_in = S_INTERP;
         end
         S_INTERP: begin
            out_in.status = awts_pkg::ST_SAMPLED;
            out_in.out_x = qpt[0];
            out_in.out_y = qpt[1];
            out_in.out_z = qpt[2];
            out_in.chosen_index = 10'(lo_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            out_in.triangle_count = 11'(count_ff);
            out_in.area_total = total_ff;
            rspv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[count_ff[AW-1:0]] <= job_ff.pa;
         mem_b[count_ff[AW-1:0]] <= job_ff.pb;
         mem_c[count_ff[AW-1:0]] <= job_ff.pc;
         mem_cum[count_ff[AW-1:0]] <= total_ff + area;
      end
      rd_a_ff <= mem_a[rd_addr];
      rd_b_ff <= mem_b[rd_addr];
      rd_c_ff <= mem_c[rd_addr];
      rd_cum_ff <= mem_cum[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         rspv_ff <= rspv_in;
      end
      job_ff <= job_in;
      e1_ff <= e1_in;
      e2_ff <= e2_in;
      cr_ff <= cr_in;
      ssum_ff <= ssum_in;
      root_ff <= root_in;
      rem_ff <= rem_in;
      it_ff <= it_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      target_ff <= target_in;
      part_ff <= part_in;
      u_ff <= u_in;
      v_ff <= v_in;
      out_ff <= out_in;
   end

endmodule
